[design/spatial_hash_cell_key_defines.svh]
// Assertion macros shared by the spatial hash cell key RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef SPATIAL_HASH_CELL_KEY_DEFINES_SVH
`define SPATIAL_HASH_CELL_KEY_DEFINES_SVH

// Implication checked in the same cycle.
`define SHCK_ASSERT_SAME(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) else $error(msg);

// Implication checked in the next cycle.
`define SHCK_ASSERT_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) else $error(msg);

`endif

[design/shck_pkg.sv]
// Package for the spatial hash cell key: constants, register codes and latencies.
// Depends on nothing.
`default_nettype none
package shck_pkg;
  // Configuration register indexes.
  localparam logic [1:0] REG_CELL_SIZE  = 2'd0;
  localparam logic [1:0] REG_TABLE_SIZE = 2'd1;

  localparam int unsigned MAX_TABLE = 65536;
  localparam int unsigned TS_W      = 17;
  localparam logic [30:0] CELL_SIZE_RST  = 31'd65536;
  localparam logic [16:0] TABLE_SIZE_RST = 17'd65536;

  // Grid block split and block multipliers.
  localparam logic [31:0] BLOCK_HALF = 32'd25;
  localparam logic [31:0] BLOCK_EDGE = 32'd50;
  localparam logic [31:0] MUL_X      = 32'd15823;
  localparam logic [31:0] MUL_Y      = 32'd9737333;
  localparam logic [31:0] MUL_Z      = 32'd440817757;
  // floor(2^36 / 50): reciprocal of the block edge, error below one.
  localparam logic [63:0] RECIP_50   = 64'd1374389534;

  // Pipeline depths.
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_LAT   = DIV_STEPS + 2;
  localparam int unsigned HASH_LAT  = 6;
  localparam int unsigned MOD_STEPS = 32;
  localparam int unsigned LAT       = DIV_LAT + HASH_LAT + MOD_STEPS;
endpackage
`default_nettype wire

[design/shck_cdiv.sv]
// Pipelined signed divider: one Q16.16 coordinate by the cell size, truncating.
// Depends on shck_pkg.
`default_nettype none
module shck_cdiv (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [30:0] divisor,
  input  wire logic [31:0] pos,
  output logic      [31:0] coord
);
  logic [31:0] n_r   [0:shck_pkg::DIV_STEPS];
  logic [30:0] r_r   [1:shck_pkg::DIV_STEPS];
  logic        sgn_r [0:shck_pkg::DIV_STEPS];
  logic [31:0] coord_r;

  logic [31:0] t_w   [1:shck_pkg::DIV_STEPS];
  logic        ge_w  [1:shck_pkg::DIV_STEPS];
  logic [31:0] dif_w [1:shck_pkg::DIV_STEPS];
  logic [31:0] d_w;

  // A zero cell size counts as the smallest step.
  assign d_w = (divisor == 31'd0) ? 32'd1 : {1'b0, divisor};

  // One restoring step per stage: shift in a dividend bit, subtract if it fits.
  always_comb begin
    for (int i = 1; i <= shck_pkg::DIV_STEPS; i++) begin
      if (i == 1) t_w[i] = {31'd0, n_r[0][31]};
      else        t_w[i] = {r_r[i-1], n_r[i-1][31]};
      ge_w[i]  = (t_w[i] >= d_w);
      dif_w[i] = t_w[i] - d_w;
    end
  end

  // Magnitude stage, step stages and sign restoring stage.
  always_ff @(posedge clk) begin
    if (en) begin
      sgn_r[0] <= pos[31];
      n_r[0]   <= pos[31] ? (32'd0 - pos) : pos;
      for (int i = 1; i <= shck_pkg::DIV_STEPS; i++) begin
        sgn_r[i] <= sgn_r[i-1];
        r_r[i]   <= ge_w[i] ? dif_w[i][30:0] : t_w[i][30:0];
        n_r[i]   <= {n_r[i-1][30:0], ge_w[i]};
      end
      coord_r <= sgn_r[shck_pkg::DIV_STEPS] ? (32'd0 - n_r[shck_pkg::DIV_STEPS])
                                            : n_r[shck_pkg::DIV_STEPS];
    end
  end

  assign coord = coord_r;
endmodule
`default_nettype wire

[design/spatial_hash_cell_key.sv]
// Spatial hash cell key: position to cell hash modulo table size, fully pipelined.
// Usage: each transfer on the in_ channel carries one particle position (signed
// Q16.16 x, y, z) and its index; each transfer on the out_ channel returns that
// index with the cell key. Exactly one result per input, in order.
// Data passes through the bit-per-stage coordinate dividers, then the block
// split and hash sum, then the bit-per-stage table size remainder.
// Throughput is one item per cycle unless the receiver stalls; the pipeline
// depth is set mostly by the 32-step restoring coordinate and remainder chains.
// The cfg_ channel writes cell_size (index 0) and table_size (index 1); it is
// always ready and must only be used while the pipeline is empty.
// Reset (rst_n low, synchronous) empties the pipeline and loads cell_size 1.0
// and table_size 65536. No clearing pass is needed.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_stall rises; nothing is lost or repeated. Empty output accepts freely.
// Depends on shck_pkg, shck_cdiv and spatial_hash_cell_key_defines.svh.
`default_nettype none
`include "spatial_hash_cell_key_defines.svh"
module spatial_hash_cell_key (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_pos_x,
  input  wire logic [31:0] in_pos_y,
  input  wire logic [31:0] in_pos_z,
  input  wire logic [15:0] in_particle_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [15:0] out_index,
  output logic      [15:0] out_cell_key,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam int unsigned L = shck_pkg::LAT;
  localparam int unsigned M = shck_pkg::MOD_STEPS;

  logic [30:0] cell_size_r;
  logic [16:0] table_size_r;
  logic        en;
  logic        v_r   [1:L];
  logic [15:0] idx_r [1:L];
  logic [31:0] cx_w, cy_w, cz_w;

  logic [31:0] ux_r, uy_r, uz_r;
  logic [31:0] u2x_r, u2y_r, u2z_r;
  logic [63:0] px_r, py_r, pz_r;
  logic [26:0] q0x_r, q0y_r, q0z_r;
  logic [6:0]  r0x_r, r0y_r, r0z_r;
  logic [26:0] bx_r, by_r, bz_r;
  logic [5:0]  lx_r, ly_r, lz_r;
  logic [31:0] mx_r, my_r, mz_r;
  logic [16:0] loc_r;
  logic [31:0] h_r;
  logic [31:0] r0x_w, r0y_w, r0z_w;

  logic [16:0] mr_r [1:M];
  logic [31:0] mh_r [1:M];
  logic [16:0] ts_w;
  logic [17:0] mt_w [1:M];
  logic        mge_w [1:M];
  logic [17:0] mdif_w [1:M];

  // The pipeline advances unless a finished result is held by the receiver.
  assign en        = !v_r[L] || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r  <= shck_pkg::CELL_SIZE_RST;
      table_size_r <= shck_pkg::TABLE_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        shck_pkg::REG_CELL_SIZE:  cell_size_r  <= cfg_data[30:0];
        shck_pkg::REG_TABLE_SIZE: table_size_r <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // Valid bits and particle index travel alongside the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= L; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[1] <= in_valid;
      for (int i = 2; i <= L; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx_r[1] <= in_particle_index;
      for (int i = 2; i <= L; i++) idx_r[i] <= idx_r[i-1];
    end
  end

  // Coordinate dividers, one per axis.
  shck_cdiv u_div_x (.clk(clk), .en(en), .divisor(cell_size_r), .pos(in_pos_x), .coord(cx_w));
  shck_cdiv u_div_y (.clk(clk), .en(en), .divisor(cell_size_r), .pos(in_pos_y), .coord(cy_w));
  shck_cdiv u_div_z (.clk(clk), .en(en), .divisor(cell_size_r), .pos(in_pos_z), .coord(cz_w));

  // Remainder estimate from the reciprocal quotient of the same item; below twice the edge.
  assign r0x_w = u2x_r - 32'(px_r[62:36]) * shck_pkg::BLOCK_EDGE;
  assign r0y_w = u2y_r - 32'(py_r[62:36]) * shck_pkg::BLOCK_EDGE;
  assign r0z_w = u2z_r - 32'(pz_r[62:36]) * shck_pkg::BLOCK_EDGE;

  // Hash stages: offset, reciprocal multiply, estimate, correct, products, sum.
  always_ff @(posedge clk) begin
    if (en) begin
      ux_r <= cx_w + shck_pkg::BLOCK_HALF;
      uy_r <= cy_w + shck_pkg::BLOCK_HALF;
      uz_r <= cz_w + shck_pkg::BLOCK_HALF;

      px_r  <= {32'd0, ux_r} * shck_pkg::RECIP_50;
      py_r  <= {32'd0, uy_r} * shck_pkg::RECIP_50;
      pz_r  <= {32'd0, uz_r} * shck_pkg::RECIP_50;
      u2x_r <= ux_r;
      u2y_r <= uy_r;
      u2z_r <= uz_r;

      q0x_r <= px_r[62:36];
      q0y_r <= py_r[62:36];
      q0z_r <= pz_r[62:36];
      r0x_r <= r0x_w[6:0];
      r0y_r <= r0y_w[6:0];
      r0z_r <= r0z_w[6:0];

      bx_r <= (r0x_r >= 7'd50) ? q0x_r + 27'd1 : q0x_r;
      by_r <= (r0y_r >= 7'd50) ? q0y_r + 27'd1 : q0y_r;
      bz_r <= (r0z_r >= 7'd50) ? q0z_r + 27'd1 : q0z_r;
      lx_r <= (r0x_r >= 7'd50) ? 6'(r0x_r - 7'd50) : r0x_r[5:0];
      ly_r <= (r0y_r >= 7'd50) ? 6'(r0y_r - 7'd50) : r0y_r[5:0];
      lz_r <= (r0z_r >= 7'd50) ? 6'(r0z_r - 7'd50) : r0z_r[5:0];

      mx_r  <= 32'(bx_r) * shck_pkg::MUL_X;
      my_r  <= 32'(by_r) * shck_pkg::MUL_Y;
      mz_r  <= 32'(bz_r) * shck_pkg::MUL_Z;
      loc_r <= 17'(lx_r) + 17'(ly_r) * 17'd50 + 17'(lz_r) * 17'd2500;

      h_r <= mx_r + my_r + mz_r + 32'(loc_r);
    end
  end

  // Effective table size: zero counts as one, large values clamp.
  assign ts_w = (table_size_r == 17'd0) ? 17'd1 :
                (32'(table_size_r) > shck_pkg::MAX_TABLE) ? 17'(shck_pkg::MAX_TABLE)
                                                          : table_size_r;

  // One restoring remainder step per stage.
  always_comb begin
    for (int j = 1; j <= M; j++) begin
      if (j == 1) mt_w[j] = {17'd0, h_r[31]};
      else        mt_w[j] = {mr_r[j-1], mh_r[j-1][31]};
      mge_w[j]  = (mt_w[j] >= {1'b0, ts_w});
      mdif_w[j] = mt_w[j] - {1'b0, ts_w};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 1; j <= M; j++) begin
        mr_r[j] <= mge_w[j] ? mdif_w[j][16:0] : mt_w[j][16:0];
        if (j == 1) mh_r[j] <= {h_r[30:0], 1'b0};
        else        mh_r[j] <= {mh_r[j-1][30:0], 1'b0};
      end
    end
  end

  assign out_valid    = v_r[L];
  assign out_index    = idx_r[L];
  assign out_cell_key = mr_r[M][15:0];

  // Checks on the pipeline control and the key range.
  `SHCK_ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall, "stall without a held result")
  `SHCK_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, v_r[1], "accepted item not in pipeline")
  `SHCK_ASSERT_SAME(a_key_range, out_valid, {1'b0, out_cell_key} < ts_w, "key not below table size")
  `SHCK_ASSERT_NEXT(a_hold_hash, in_stall, $stable(h_r) && $stable(mr_r[M]), "stalled stage moved")
endmodule
`default_nettype wire
